### src/pim_pkg.sv
// shared constants and types for the pending insertion merger
package pim_pkg;

	localparam int PENDING_DEPTH = 32;
	localparam int POSITION_BITS = 16;
	localparam int ITEM_BITS     = 32;

	localparam int ADDR_W    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CNT_W     = $clog2(PENDING_DEPTH + 1);
	localparam int INDEX_W   = POSITION_BITS + 1;
	localparam int ENTRY_W   = POSITION_BITS + ITEM_BITS;
	localparam int S_TDATA_W = ((POSITION_BITS + ITEM_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((ITEM_BITS + 7) / 8) * 8;
	localparam int FUNC_W    = 2;
	localparam int KIND_W    = 3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_QUEUE   = 2'd0,
		FUNC_ELEMENT = 2'd1,
		FUNC_END     = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ELEMENT  = 3'd0,
		KIND_INSERTED = 3'd1,
		KIND_END      = 3'd2,
		KIND_REJECTED = 3'd3,
		KIND_DROPPED  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_EMIT
	} state_t;

endpackage

### src/pim_ram.sv
// generic single-write, single-read ram with registered read data
module pim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/pending_insertion_merger_unit.sv
// pending insertion merger: store of queued insertions merged into a streamed sequence
// a queue item is stored, and gives no result unless the store is full
// an element or end item reads and compares each stored entry in turn (ram read, then
// compare), then loads its last result; the next item waits until the unit is idle
// an empty store skips the scan; output backpressure adds stalls
// arst_n clears the fill count, element index, state and output valid; ram content is
// not cleared, entries at or above the fill count are never read
module pending_insertion_merger_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// position, value
	input  logic [pim_pkg::S_TDATA_W-1:0] s_tdata,
	// func
	input  logic [pim_pkg::FUNC_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// value_res
	output logic [pim_pkg::M_TDATA_W-1:0] m_tdata,
	// kind
	output logic [pim_pkg::KIND_W-1:0]    m_tuser,
	output logic                          m_tlast
);

	pim_pkg::state_t state_q, state_nxt;
	pim_pkg::func_t  func_q;
	logic [pim_pkg::ITEM_BITS-1:0] val_q;
	logic [pim_pkg::CNT_W-1:0]     count_q;
	logic [pim_pkg::CNT_W-1:0]     keep_q;
	logic [pim_pkg::CNT_W-1:0]     idx_q;
	logic [pim_pkg::INDEX_W-1:0]   index_q;

	logic                          out_valid_q;
	logic [pim_pkg::ITEM_BITS-1:0] out_value_q;
	pim_pkg::kind_t                out_kind_q;
	logic                          out_last_q;

	// input fields
	pim_pkg::func_t                in_func;
	logic [pim_pkg::POSITION_BITS-1:0] in_pos;
	logic [pim_pkg::ITEM_BITS-1:0] in_val;
	logic                          in_xfer;
	logic                          full;

	// ram signals
	logic                          wr_en;
	logic [pim_pkg::ADDR_W-1:0]    wr_addr;
	logic [pim_pkg::ENTRY_W-1:0]   wr_data;
	logic                          rd_en;
	logic [pim_pkg::ENTRY_W-1:0]   rd_data;
	logic [pim_pkg::POSITION_BITS-1:0] rd_pos;
	logic [pim_pkg::ITEM_BITS-1:0] rd_val;

	// datapath control
	logic                          out_free;
	logic                          out_load;
	logic [pim_pkg::ITEM_BITS-1:0] out_value;
	pim_pkg::kind_t                out_kind;
	logic                          out_last;
	logic                          match;
	logic                          emit;
	logic                          advance;
	logic                          scan_done;

	assign in_func = pim_pkg::func_t'(s_tuser);
	assign in_pos  = s_tdata[pim_pkg::POSITION_BITS-1:0];
	assign in_val  = s_tdata[pim_pkg::POSITION_BITS +: pim_pkg::ITEM_BITS];
	assign s_tready = (state_q == pim_pkg::ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign full     = (count_q == pim_pkg::CNT_W'(pim_pkg::PENDING_DEPTH));
	assign out_free = !out_valid_q || m_tready;

	assign rd_pos    = rd_data[pim_pkg::POSITION_BITS-1:0];
	assign rd_val    = rd_data[pim_pkg::ENTRY_W-1:pim_pkg::POSITION_BITS];
	assign match     = ({1'b0, rd_pos} == index_q);
	assign emit      = (func_q == pim_pkg::FUNC_END) || match;
	assign scan_done = ((idx_q + 1'b1) == count_q);

	pim_ram #(
		.WIDTH(pim_pkg::ENTRY_W),
		.DEPTH(pim_pkg::PENDING_DEPTH)
	) u_pending_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(idx_q[pim_pkg::ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	// fsm outputs
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = count_q[pim_pkg::ADDR_W-1:0];
		wr_data   = {in_val, in_pos};
		rd_en     = 1'b0;
		out_load  = 1'b0;
		out_value = rd_val;
		out_kind  = pim_pkg::KIND_INSERTED;
		out_last  = 1'b0;
		advance   = 1'b0;
		unique case (state_q)
			pim_pkg::ST_IDLE: begin
				if (in_xfer && in_func == pim_pkg::FUNC_QUEUE && !full) begin
					wr_en = 1'b1;
				end
			end
			pim_pkg::ST_SCAN_RD: begin
				rd_en = 1'b1;
			end
			pim_pkg::ST_SCAN_EV: begin
				if (emit) begin
					out_load = out_free;
					out_kind = match ? pim_pkg::KIND_INSERTED : pim_pkg::KIND_DROPPED;
					advance  = out_free;
				end else begin
					// keep the entry, compacted toward the front
					wr_en   = 1'b1;
					wr_addr = keep_q[pim_pkg::ADDR_W-1:0];
					wr_data = rd_data;
					advance = 1'b1;
				end
			end
			pim_pkg::ST_EMIT: begin
				out_load  = out_free;
				out_last  = 1'b1;
				out_value = (func_q == pim_pkg::FUNC_END) ? '0 : val_q;
				case (func_q)
					pim_pkg::FUNC_QUEUE:   out_kind = pim_pkg::KIND_REJECTED;
					pim_pkg::FUNC_ELEMENT: out_kind = pim_pkg::KIND_ELEMENT;
					default:               out_kind = pim_pkg::KIND_END;
				endcase
			end
			default: begin
			end
		endcase
	end

	// fsm next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pim_pkg::ST_IDLE: begin
				if (in_xfer) begin
					unique case (in_func)
						pim_pkg::FUNC_QUEUE:
							state_nxt = full ? pim_pkg::ST_EMIT : pim_pkg::ST_IDLE;
						pim_pkg::FUNC_ELEMENT, pim_pkg::FUNC_END:
							state_nxt = (count_q == '0) ? pim_pkg::ST_EMIT
							                           : pim_pkg::ST_SCAN_RD;
						default:
							state_nxt = pim_pkg::ST_IDLE;
					endcase
				end
			end
			pim_pkg::ST_SCAN_RD: state_nxt = pim_pkg::ST_SCAN_EV;
			pim_pkg::ST_SCAN_EV: begin
				if (advance) begin
					state_nxt = scan_done ? pim_pkg::ST_EMIT : pim_pkg::ST_SCAN_RD;
				end
			end
			pim_pkg::ST_EMIT: begin
				if (out_load) begin
					state_nxt = pim_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pim_pkg::ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pim_pkg::ST_IDLE;
			count_q <= '0;
			index_q <= '0;
			keep_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_xfer) begin
				keep_q <= '0;
				idx_q  <= '0;
				if (in_func == pim_pkg::FUNC_QUEUE && !full) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == pim_pkg::ST_SCAN_EV && advance) begin
				idx_q <= idx_q + 1'b1;
				if (!emit) begin
					keep_q <= keep_q + 1'b1;
				end
			end
			// element and end results close the item and commit the store
			if (state_q == pim_pkg::ST_EMIT && out_load) begin
				if (func_q == pim_pkg::FUNC_ELEMENT) begin
					count_q <= keep_q;
					if (index_q != '1) begin
						index_q <= index_q + 1'b1;
					end
				end else if (func_q == pim_pkg::FUNC_END) begin
					count_q <= '0;
					index_q <= '0;
				end
			end
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= in_func;
			val_q  <= in_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= out_value;
			out_kind_q  <= out_kind;
			out_last_q  <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pim_pkg::M_TDATA_W'(out_value_q);
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

### src/pim_checker.sv
// port-level checks for the pending insertion merger, bound to the top level
module pim_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [pim_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [pim_pkg::FUNC_W-1:0]    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pim_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [pim_pkg::KIND_W-1:0]    m_tuser,
	input logic                          m_tlast
);

	// a stalled result transfer holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
	else $error("stalled result changed");

	// end marker carries zero and closes the item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pim_pkg::KIND_END |-> m_tdata == '0 && m_tlast)
	else $error("end marker malformed");

	// element and reject results are always the final result of their item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == pim_pkg::KIND_ELEMENT || m_tuser == pim_pkg::KIND_REJECTED)
		|-> m_tlast)
	else $error("element or reject without last");

	// scanned entries never close the item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == pim_pkg::KIND_INSERTED || m_tuser == pim_pkg::KIND_DROPPED)
		|-> !m_tlast)
	else $error("inserted or dropped entry marked last");

endmodule

bind pending_insertion_merger_unit pim_checker u_pim_checker (.*);

### tb/pending_insertion_merger_unit_tb.sv
// self-checking testbench for the pending insertion merger unit
module pending_insertion_merger_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 280;
	localparam int TAIL_CYCLES    = 20;

	typedef struct packed {
		logic [pim_pkg::ITEM_BITS-1:0] value;
		pim_pkg::kind_t                kind;
		logic                          last;
	} merged_t;

	typedef struct {
		pim_pkg::func_t                    f;
		logic [pim_pkg::POSITION_BITS-1:0] pos;
		logic [pim_pkg::ITEM_BITS-1:0]     val;
		bit                                typed;
		logic [pim_pkg::ITEM_BITS-1:0]     typed_val;
		pim_pkg::kind_t                    typed_kind;
	} plan_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [pim_pkg::S_TDATA_W-1:0] s_tdata;
	logic [pim_pkg::FUNC_W-1:0]    s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [pim_pkg::M_TDATA_W-1:0] m_tdata;
	logic [pim_pkg::KIND_W-1:0]    m_tuser;
	logic                          m_tlast;

	// shadow copy of the pending store
	logic [pim_pkg::POSITION_BITS-1:0] shadow_pos [pim_pkg::PENDING_DEPTH];
	logic [pim_pkg::ITEM_BITS-1:0]     shadow_val [pim_pkg::PENDING_DEPTH];
	int                                shadow_cnt;
	logic [pim_pkg::INDEX_W-1:0]       shadow_index;

	merged_t merge_out[$];
	merged_t due_out[$];

	int  mismatches;
	int  items_sent;
	int  stalled;
	bit  idle_on;
	bit  typed_valid;
	logic [pim_pkg::ITEM_BITS-1:0] typed_value;
	pim_pkg::kind_t                typed_kind;

	pending_insertion_merger_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void add_result(input logic [pim_pkg::ITEM_BITS-1:0] v, input pim_pkg::kind_t k);
		merged_t r;
		r.value = v;
		r.kind  = k;
		r.last  = 1'b0;
		merge_out.insert(merge_out.size(), r);
	endfunction

	// expected output transfers for one accepted input item
	function void merge_item(input pim_pkg::func_t f,
			input logic [pim_pkg::POSITION_BITS-1:0] p,
			input logic [pim_pkg::ITEM_BITS-1:0] v);
		int keep;
		merge_out.delete();
		case (f)
			pim_pkg::FUNC_QUEUE: begin
				if (shadow_cnt >= pim_pkg::PENDING_DEPTH) begin
					add_result(v, pim_pkg::KIND_REJECTED);
				end else begin
					shadow_pos[shadow_cnt] = p;
					shadow_val[shadow_cnt] = v;
					shadow_cnt++;
				end
			end
			pim_pkg::FUNC_ELEMENT: begin
				// matching entries go out in arrival order, the rest are compacted
				keep = 0;
				for (int i = 0; i < shadow_cnt; i++) begin
					if ({1'b0, shadow_pos[i]} == shadow_index) begin
						add_result(shadow_val[i], pim_pkg::KIND_INSERTED);
					end else begin
						shadow_pos[keep] = shadow_pos[i];
						shadow_val[keep] = shadow_val[i];
						keep++;
					end
				end
				shadow_cnt = keep;
				add_result(v, pim_pkg::KIND_ELEMENT);
				if (shadow_index != '1)
					shadow_index++;
			end
			pim_pkg::FUNC_END: begin
				for (int i = 0; i < shadow_cnt; i++) begin
					if ({1'b0, shadow_pos[i]} == shadow_index)
						add_result(shadow_val[i], pim_pkg::KIND_INSERTED);
					else
						add_result(shadow_val[i], pim_pkg::KIND_DROPPED);
				end
				add_result('0, pim_pkg::KIND_END);
				shadow_cnt   = 0;
				shadow_index = '0;
			end
			default: begin
			end
		endcase
		if (merge_out.size() > 0)
			merge_out[merge_out.size()-1].last = 1'b1;
	endfunction

	function void report_mismatch(input bit had_want, input merged_t want, input merged_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (had_want)
				$display("mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
					want.value, want.kind, want.last, got.value, got.kind, got.last);
			else
				$display("unexpected transfer: value %h kind %0d last %0b",
					got.value, got.kind, got.last);
		end
	endfunction

	// predict on accepted input, check accepted output, watch for a hang
	always @(posedge clk) begin : monitor
		merged_t got;
		merged_t want;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				merge_item(pim_pkg::func_t'(s_tuser), s_tdata[pim_pkg::POSITION_BITS-1:0],
					s_tdata[pim_pkg::POSITION_BITS +: pim_pkg::ITEM_BITS]);
				if (typed_valid) begin
					want.value = typed_value;
					want.kind  = typed_kind;
					want.last  = 1'b1;
					due_out.insert(due_out.size(), want);
				end else begin
					foreach (merge_out[i])
						due_out.insert(due_out.size(), merge_out[i]);
				end
			end
			if (m_tvalid && m_tready) begin
				moved     = 1'b1;
				got.value = m_tdata[pim_pkg::ITEM_BITS-1:0];
				got.kind  = pim_pkg::kind_t'(m_tuser);
				got.last  = m_tlast;
				if (due_out.size() == 0) begin
					report_mismatch(1'b0, got, got);
				end else begin
					want = due_out.pop_front();
					if (got.value !== want.value || got.kind !== want.kind
							|| got.last !== want.last)
						report_mismatch(1'b1, want, got);
				end
			end
			if (moved) begin
				stalled = 0;
			end else begin
				stalled++;
				if (stalled >= WATCHDOG_LIMIT) begin
					$display("FAIL pending_insertion_merger_unit");
					$finish;
				end
			end
		end
	end

	// output backpressure: mostly short stalls, a few long ones
	initial begin : receiver
		int stall_left;
		int r;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 20)
					stall_left = $urandom_range(1, 3);
				else if (r < 24)
					stall_left = $urandom_range(10, 40);
			end
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function logic [pim_pkg::ITEM_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		else
			return $urandom;
	endfunction

	function logic [pim_pkg::POSITION_BITS-1:0] rand_pos();
		return pim_pkg::POSITION_BITS'($urandom);
	endfunction

	// present one item and hold it until the transfer
	task send_item(input pim_pkg::func_t f, input logic [pim_pkg::POSITION_BITS-1:0] p,
			input logic [pim_pkg::ITEM_BITS-1:0] v, input bit typed,
			input logic [pim_pkg::ITEM_BITS-1:0] tv, input pim_pkg::kind_t tk);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		typed_valid = typed;
		typed_value = tv;
		typed_kind  = tk;
		s_tvalid <= 1'b1;
		s_tdata  <= pim_pkg::S_TDATA_W'({v, p});
		s_tuser  <= f;
		do
			@(posedge clk);
		while (!s_tready);
		if (f != pim_pkg::FUNC_NOP)
			items_sent++;
	endtask

	task send(input pim_pkg::func_t f, input logic [pim_pkg::POSITION_BITS-1:0] p,
			input logic [pim_pkg::ITEM_BITS-1:0] v);
		send_item(f, p, v, 1'b0, '0, pim_pkg::KIND_ELEMENT);
	endtask

	// drop valid and hold off until every expected transfer has come
	task wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_out.size() != 0)
			@(posedge clk);
	endtask

	// one sequence: insertions interleaved with elements, then an end
	task run_sequence(input bit overfill);
		int len;
		int n_ins;
		int done_el;
		int done_q;
		int r;
		logic [pim_pkg::POSITION_BITS-1:0] p;
		len     = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
		n_ins   = overfill ? $urandom_range(33, 36) : $urandom_range(0, 7);
		done_el = 0;
		done_q  = 0;
		while (done_el < len || done_q < n_ins) begin
			if (done_q < n_ins && (done_el >= len || $urandom_range(0, 1) == 1)) begin
				r = $urandom_range(0, 9);
				if (r < 6)
					p = pim_pkg::POSITION_BITS'($urandom_range(done_el, len));
				else if (r < 8)
					p = pim_pkg::POSITION_BITS'($urandom_range(0, len));
				else if (r == 8)
					p = $urandom_range(0, 1) ? '1 : '0;
				else
					p = rand_pos();
				send(pim_pkg::FUNC_QUEUE, p, pick_value());
				done_q++;
			end else begin
				send(pim_pkg::FUNC_ELEMENT, rand_pos(), pick_value());
				done_el++;
			end
			if ($urandom_range(0, 19) == 0)
				send(pim_pkg::FUNC_NOP, rand_pos(), $urandom);
		end
		send(pim_pkg::FUNC_END, rand_pos(), $urandom);
	endtask

	// unstructured items of any function
	task run_noise();
		int n;
		n = $urandom_range(4, 12);
		repeat (n)
			send(pim_pkg::func_t'($urandom_range(0, 3)), rand_pos(), pick_value());
	endtask

	initial begin : stimulus
		plan_row_t plan[20];
		int        rand_start;
		int        r;

		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		arst_n       = 1'b0;
		idle_on      = 1'b1;
		typed_valid  = 1'b0;
		typed_value  = '0;
		typed_kind   = pim_pkg::KIND_ELEMENT;
		mismatches   = 0;
		items_sent   = 0;
		stalled      = 0;
		shadow_cnt   = 0;
		shadow_index = '0;

		plan = '{
			// end right after reset: marker only
			'{pim_pkg::FUNC_END,     16'h0, 32'h0, 1'b1, 32'h0, pim_pkg::KIND_END},
			'{pim_pkg::FUNC_ELEMENT, 16'h0, 32'hffffffff, 1'b1, 32'hffffffff, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_NOP,     16'hffff, 32'hffffffff, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_ELEMENT, 16'hffff, 32'h0, 1'b1, 32'h0, pim_pkg::KIND_ELEMENT},
			// late insertion, two at one position, one far out of range
			'{pim_pkg::FUNC_QUEUE,   16'h0, 32'ha5a5a5a5, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_QUEUE,   16'h2, 32'h0, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_QUEUE,   16'h2, 32'hffffffff, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_QUEUE,   16'hffff, 32'h12345678, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_QUEUE,   16'h3, 32'h1, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_ELEMENT, 16'h0, 32'h11, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_ELEMENT, 16'h0, 32'h22, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			// one at the sequence length, one beyond it
			'{pim_pkg::FUNC_QUEUE,   16'h4, 32'h33, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_QUEUE,   16'h5, 32'h44, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_END,     16'h0, 32'h0, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			// empty sequence with an insertion at zero
			'{pim_pkg::FUNC_QUEUE,   16'h0, 32'h55, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_END,     16'hffff, 32'hffffffff, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_QUEUE,   16'h0, 32'h66, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_NOP,     16'h0, 32'h0, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_ELEMENT, 16'h0, 32'h77, 1'b0, 32'h0, pim_pkg::KIND_ELEMENT},
			'{pim_pkg::FUNC_END,     16'h0, 32'h0, 1'b1, 32'h0, pim_pkg::KIND_END}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows
		foreach (plan[i])
			send_item(plan[i].f, plan[i].pos, plan[i].val, plan[i].typed,
				plan[i].typed_val, plan[i].typed_kind);
		wait_idle();

		// random sequences, the first one overfills the store
		rand_start = items_sent;
		run_sequence(1'b1);
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 4) != 0);
			r = $urandom_range(0, 99);
			if (r < 12)
				run_noise();
			else
				run_sequence($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 5) == 0)
				wait_idle();
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_out.size() == 0)
			$display("PASS pending_insertion_merger_unit");
		else
			$display("FAIL pending_insertion_merger_unit");
		$finish;
	end

endmodule
